@@ rtl/core/spom_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spom_pkg
// shared types and constants of the spiral-order matrix reader
// ----------------------------------------------------------------------------
package spom_pkg;

  localparam int MaxRows   = 16;
  localparam int MaxCols   = 16;
  localparam int DataWidth = 32;

  localparam int Depth = MaxRows * MaxCols;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int RowW  = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int ColW  = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int IdxW  = (RowW > ColW) ? RowW : ColW;

  // size registers, as seen on the config port
  localparam int CfgW      = 5;
  localparam int CfgIdxW   = 8;
  localparam int CfgDataW  = 32;
  localparam int EdgeW     = ((IdxW > CfgW) ? IdxW : CfgW) + 2;

  localparam logic [CfgW-1:0]    SizeReset    = CfgW'(16);
  localparam logic [CfgIdxW-1:0] RegNumRows   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegNumCols   = CfgIdxW'(1);

  localparam int ValueW = 32;

  typedef logic signed [EdgeW-1:0] edge_t;

  typedef struct packed {
    logic                     action;
    logic signed [ValueW-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] spiral_value;
    logic                     last_of_spiral;
  } out_item_t;

  // store access request from the position logic
  typedef struct packed {
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
    logic             last;
  } spom_req_t;

  localparam logic ActLoad = 1'b0;
  localparam logic ActRead = 1'b1;

endpackage

@@ rtl/core/spom_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spom_ram
// single-port ram, registered read
// ----------------------------------------------------------------------------
module spom_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/spom_walker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spom_walker
// size registers, row-major load position and spiral cursor
// ----------------------------------------------------------------------------
module spom_walker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  input  logic                            action_i,
  input  logic                            cfg_we_i,
  input  logic [spom_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [spom_pkg::CfgDataW-1:0]   cfg_data_i,
  output spom_pkg::spom_req_t             req_o
);
  import spom_pkg::*;

  typedef enum logic [1:0] {
    SIDE_TOP,
    SIDE_RIGHT,
    SIDE_BOTTOM,
    SIDE_LEFT
  } side_e;

  function automatic logic [CfgW-1:0] eff_size(input logic [CfgW-1:0] raw, input int max_v);
    logic [CfgW-1:0] r;
    if (raw == '0) r = CfgW'(1);
    else if (int'(raw) > max_v) r = CfgW'(max_v);
    else r = raw;
    return r;
  endfunction

  function automatic edge_t to_edge(input logic [IdxW-1:0] v);
    return $signed({{(EdgeW-IdxW){1'b0}}, v});
  endfunction

  logic [CfgW-1:0]  num_rows_q, num_rows_d, num_cols_q, num_cols_d;
  logic [CntW-1:0]  load_pos_q, load_pos_d;
  edge_t            left_q, left_d, right_q, right_d, top_q, top_d, bottom_q, bottom_d;
  side_e            side_q, side_d;
  logic [IdxW-1:0]  row_q, row_d, col_q, col_d;

  logic [CfgW-1:0]  rows_eff, cols_eff, new_rows_eff, new_cols_eff;
  logic [CntW-1:0]  total, load_addr, load_next;
  logic             restart, layer_done, last;
  logic             do_load, do_read, cfg_hit;
  edge_t            row_e, col_e, left_n, right_n, top_n, bottom_n;

  assign rows_eff = eff_size(num_rows_q, MaxRows);
  assign cols_eff = eff_size(num_cols_q, MaxCols);
  assign total    = CntW'(rows_eff) * CntW'(cols_eff);

  assign do_load = item_valid_i && (action_i == ActLoad);
  assign do_read = item_valid_i && (action_i == ActRead);
  assign cfg_hit = cfg_we_i && ((cfg_index_i == RegNumRows) || (cfg_index_i == RegNumCols));

  assign load_addr = (load_pos_q >= total) ? '0 : load_pos_q;
  assign load_next = load_addr + CntW'(1);

  assign row_e = to_edge(row_q);
  assign col_e = to_edge(col_q);

  assign left_n   = left_q + edge_t'(1);
  assign right_n  = right_q - edge_t'(1);
  assign top_n    = top_q + edge_t'(1);
  assign bottom_n = bottom_q - edge_t'(1);

  // next cursor along the spiral
  always_comb begin
    side_d     = side_q;
    row_d      = row_q;
    col_d      = col_q;
    left_d     = left_q;
    right_d    = right_q;
    top_d      = top_q;
    bottom_d   = bottom_q;
    layer_done = 1'b0;
    last       = 1'b0;
    unique case (side_q)
      SIDE_TOP: begin
        if (col_e < right_q) begin
          col_d = col_q + IdxW'(1);
        end else if (top_q < bottom_q) begin
          side_d = SIDE_RIGHT;
          row_d  = top_n[IdxW-1:0];
          col_d  = right_q[IdxW-1:0];
        end else begin
          layer_done = 1'b1;
        end
      end
      SIDE_RIGHT: begin
        if (row_e < bottom_q) begin
          row_d = row_q + IdxW'(1);
        end else if (left_q < right_q) begin
          side_d = SIDE_BOTTOM;
          col_d  = right_n[IdxW-1:0];
          row_d  = bottom_q[IdxW-1:0];
        end else begin
          layer_done = 1'b1;
        end
      end
      SIDE_BOTTOM: begin
        if (col_e > left_q) begin
          col_d = col_q - IdxW'(1);
        end else if (bottom_n > top_q) begin
          side_d = SIDE_LEFT;
          row_d  = bottom_n[IdxW-1:0];
          col_d  = left_q[IdxW-1:0];
        end else begin
          layer_done = 1'b1;
        end
      end
      SIDE_LEFT: begin
        if (row_e > top_n) begin
          row_d = row_q - IdxW'(1);
        end else begin
          layer_done = 1'b1;
        end
      end
      default: begin
        layer_done = 1'b1;
      end
    endcase
    if (layer_done) begin
      left_d   = left_n;
      right_d  = right_n;
      top_d    = top_n;
      bottom_d = bottom_n;
      if ((left_n <= right_n) && (top_n <= bottom_n)) begin
        side_d = SIDE_TOP;
        row_d  = top_n[IdxW-1:0];
        col_d  = left_n[IdxW-1:0];
      end else begin
        last = 1'b1;
      end
    end
  end

  always_comb begin
    num_rows_d = num_rows_q;
    num_cols_d = num_cols_q;
    if (cfg_we_i && (cfg_index_i == RegNumRows)) num_rows_d = cfg_data_i[CfgW-1:0];
    if (cfg_we_i && (cfg_index_i == RegNumCols)) num_cols_d = cfg_data_i[CfgW-1:0];
  end

  assign new_rows_eff = eff_size(num_rows_d, MaxRows);
  assign new_cols_eff = eff_size(num_cols_d, MaxCols);
  assign restart      = cfg_hit || (do_read && last);
  assign load_pos_d   = (load_next >= total) ? '0 : load_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= SizeReset;
      num_cols_q <= SizeReset;
      load_pos_q <= '0;
      left_q     <= '0;
      right_q    <= edge_t'(eff_size(SizeReset, MaxCols)) - edge_t'(1);
      top_q      <= '0;
      bottom_q   <= edge_t'(eff_size(SizeReset, MaxRows)) - edge_t'(1);
      side_q     <= SIDE_TOP;
      row_q      <= '0;
      col_q      <= '0;
    end else begin
      num_rows_q <= num_rows_d;
      num_cols_q <= num_cols_d;
      if (restart) begin
        load_pos_q <= '0;
        left_q     <= '0;
        right_q    <= edge_t'(new_cols_eff) - edge_t'(1);
        top_q      <= '0;
        bottom_q   <= edge_t'(new_rows_eff) - edge_t'(1);
        side_q     <= SIDE_TOP;
        row_q      <= '0;
        col_q      <= '0;
      end else if (do_load) begin
        load_pos_q <= load_pos_d;
      end else if (do_read) begin
        left_q   <= left_d;
        right_q  <= right_d;
        top_q    <= top_d;
        bottom_q <= bottom_d;
        side_q   <= side_d;
        row_q    <= row_d;
        col_q    <= col_d;
      end
    end
  end

  always_comb begin
    req_o.we   = do_load;
    req_o.re   = do_read;
    req_o.last = last;
    if (action_i == ActLoad) begin
      req_o.addr = AddrW'(load_addr);
    end else begin
      req_o.addr = AddrW'(row_q * cols_eff + CntW'(col_q));
    end
  end

endmodule

@@ rtl/core/spiral_order_matrix_reader_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiral_order_matrix_reader_top
// matrix store filled row-major and read back in clockwise spiral order
// ----------------------------------------------------------------------------
// One item is taken on every clock edge where start is high; busy is always
// low. A load item writes the next row-major entry and gives no result. A read
// item gives its result in the cycle after the transfer, with
// result_strobe_o high for that single cycle; the receiver cannot stall, so it
// must take each result when the strobe shows it. The figure of one item per
// cycle comes from the single-port store: each item makes one access to it,
// and the read data comes from the ram's output register. The store reads as
// zero after reset without a clearing pass: one valid flag per entry marks the
// entries written since reset. Size writes on the config port are always
// ready; they restart the load position and the spiral and keep the store.
// ----------------------------------------------------------------------------
module spiral_order_matrix_reader_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  spom_pkg::in_item_t              in_item_i,
  output logic                            result_strobe_o,
  output spom_pkg::out_item_t             result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [spom_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [spom_pkg::CfgDataW-1:0]   cfg_data_i
);
  import spom_pkg::*;

  spom_req_t             req;
  logic                  item_valid;
  logic [Depth-1:0]      valid_q;
  logic                  rd_valid_q;
  logic                  strobe_q;
  logic                  last_q;
  logic [DataWidth-1:0]  rdata;

  // never stalls: one item per cycle
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign item_valid  = start && !busy;

  // position and spiral cursor logic
  spom_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .action_i     (in_item_i.action),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .req_o        (req)
  );

  // element store, elements kept at DataWidth bits
  spom_ram #(
    .Width (DataWidth),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req.we),
    .re_i    (req.re),
    .addr_i  (req.addr),
    .wdata_i (DataWidth'(in_item_i.element_value)),
    .rdata_o (rdata)
  );

  // written-since-reset flags, result strobe and last marker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      strobe_q   <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      strobe_q <= req.re;
      if (req.we) begin
        valid_q[req.addr] <= 1'b1;
      end
      if (req.re) begin
        rd_valid_q <= valid_q[req.addr];
        last_q     <= req.last;
      end
    end
  end

  // never-written entries read as zero; stored value is sign-extended
  assign result_strobe_o         = strobe_q;
  assign result_o.spiral_value   = rd_valid_q ? ValueW'(signed'(rdata)) : '0;
  assign result_o.last_of_spiral = last_q;

endmodule
